// ===== hw/rtl/scm_pkg.sv =====
// Shared types and codes for the stack calculator machine.
package scm_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_DUP    = 3'd2,
        CMD_ADD    = 3'd3,
        CMD_SUB    = 3'd4,
        CMD_MUL    = 3'd5,
        CMD_DIV    = 3'd6,
        CMD_FINISH = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_UNDER    = 3'd1,
        STAT_DIVZERO  = 3'd2,
        STAT_OVER     = 3'd3,
        STAT_NOVALUE  = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t               cmd;
        logic signed [31:0] operand;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] top_value;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIN_RD,
        ST_DUP_RD,
        ST_RD_B,
        ST_RD_A,
        ST_EXEC,
        ST_MUL,
        ST_ABS_A,
        ST_ABS_B,
        ST_DIV,
        ST_DIV_FIX,
        ST_WB,
        ST_EMIT
    } state_t;

endpackage

// ===== hw/rtl/stack_calculator_machine_top.sv =====
// Stack calculator: push/pop complete in idle; dup reads the top, then writes the copy;
// binary ops read, execute and write back; finish emits the top or no value if empty.
// Mul and div run one bit per cycle through a single shared adder/subtractor,
// which sets the rate: one item at a time, new beat taken only in idle.
// Stack reads go through the registered RAM port.
// Reset clears state, stack pointer, halt flag and result valid; stack RAM is not cleared.
module stack_calculator_machine_top #(
    parameter int STACK_DEPTH = 1024,
    parameter int DATA_WIDTH  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  scm_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output scm_pkg::rsp_t rsp_data
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int CW = $clog2(DATA_WIDTH);
    localparam int W  = DATA_WIDTH;

    scm_pkg::state_t state_reg, state_next;
    logic [PW-1:0]   sp_reg, sp_next;
    logic            halted_reg, halted_next;
    logic            out_valid_reg, out_valid_next;
    scm_pkg::rsp_t   rsp_reg, rsp_next;
    scm_pkg::rsp_t   res_reg, res_next;
    scm_pkg::cmd_t   cmd_reg, cmd_next;
    logic [W-1:0]    a_reg, a_next;
    logic [W-1:0]    b_reg, b_next;
    logic [W:0]      acc_reg, acc_next;
    logic [W-1:0]    word_reg, word_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            neg_reg, neg_next;

    logic [PW-1:0]   sp_m1, sp_m2;
    logic            wr_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [W-1:0]    wr_data, rd_data;
    logic [W-1:0]    opnd_word;
    logic [63:0]     opnd_ext, rd_ext;

    // shared adder/subtractor
    logic [W:0]      alu_x, alu_y, alu_sum;
    logic            alu_sub;

    assign alu_sum = alu_x + (alu_sub ? ~alu_y : alu_y) + (W+1)'(alu_sub);

    assign sp_m1 = sp_reg - PW'(1);
    assign sp_m2 = sp_reg - PW'(2);

    assign opnd_ext  = 64'(req_data.operand);
    assign opnd_word = opnd_ext[W-1:0];
    assign rd_ext    = 64'($signed(rd_data));

    scm_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_stall = (state_reg != scm_pkg::ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scm_pkg::ST_IDLE;
            sp_reg        <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        res_reg  <= res_next;
        cmd_reg  <= cmd_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        word_reg <= word_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        halted_next    = halted_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        res_next       = res_reg;
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        wr_en          = 1'b0;
        wr_addr        = sp_reg[AW-1:0];
        wr_data        = opnd_word;
        rd_addr        = sp_m1[AW-1:0];
        alu_x          = '0;
        alu_y          = '0;
        alu_sub        = 1'b0;

        unique case (state_reg)
            scm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next = req_data.cmd;
                    if (req_data.cmd == scm_pkg::CMD_FINISH)
                    begin
                        sp_next     = '0;
                        halted_next = 1'b0;
                        if (!halted_reg)
                        begin
                            if (sp_reg == '0)
                            begin
                                res_next   = '{status: scm_pkg::STAT_NOVALUE, top_value: '0};
                                state_next = scm_pkg::ST_EMIT;
                            end
                            else
                            begin
                                state_next = scm_pkg::ST_FIN_RD;
                            end
                        end
                    end
                    else if (!halted_reg)
                    begin
                        unique case (req_data.cmd)
                            scm_pkg::CMD_PUSH:
                            begin
                                if (sp_reg == PW'(STACK_DEPTH))
                                begin
                                    res_next    = '{status: scm_pkg::STAT_OVER, top_value: '0};
                                    halted_next = 1'b1;
                                    state_next  = scm_pkg::ST_EMIT;
                                end
                                else
                                begin
                                    wr_en   = 1'b1;
                                    sp_next = sp_reg + PW'(1);
                                end
                            end
                            scm_pkg::CMD_POP:
                            begin
                                if (sp_reg == '0)
                                begin
                                    res_next    = '{status: scm_pkg::STAT_UNDER, top_value: '0};
                                    halted_next = 1'b1;
                                    state_next  = scm_pkg::ST_EMIT;
                                end
                                else
                                begin
                                    sp_next = sp_m1;
                                end
                            end
                            scm_pkg::CMD_DUP:
                            begin
                                if (sp_reg == '0)
                                begin
                                    res_next    = '{status: scm_pkg::STAT_UNDER, top_value: '0};
                                    halted_next = 1'b1;
                                    state_next  = scm_pkg::ST_EMIT;
                                end
                                else if (sp_reg == PW'(STACK_DEPTH))
                                begin
                                    res_next    = '{status: scm_pkg::STAT_OVER, top_value: '0};
                                    halted_next = 1'b1;
                                    state_next  = scm_pkg::ST_EMIT;
                                end
                                else
                                begin
                                    state_next = scm_pkg::ST_DUP_RD;
                                end
                            end
                            default:
                            begin
                                // binary operators
                                if (sp_reg < PW'(2))
                                begin
                                    res_next    = '{status: scm_pkg::STAT_UNDER, top_value: '0};
                                    halted_next = 1'b1;
                                    state_next  = scm_pkg::ST_EMIT;
                                end
                                else
                                begin
                                    state_next = scm_pkg::ST_RD_B;
                                end
                            end
                        endcase
                    end
                end
            end
            scm_pkg::ST_FIN_RD:
            begin
                res_next   = '{status: scm_pkg::STAT_OK, top_value: rd_ext[31:0]};
                state_next = scm_pkg::ST_EMIT;
            end
            scm_pkg::ST_DUP_RD:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                sp_next    = sp_reg + PW'(1);
                state_next = scm_pkg::ST_IDLE;
            end
            scm_pkg::ST_RD_B:
            begin
                b_next     = rd_data;
                rd_addr    = sp_m2[AW-1:0];
                state_next = scm_pkg::ST_RD_A;
            end
            scm_pkg::ST_RD_A:
            begin
                a_next     = rd_data;
                state_next = scm_pkg::ST_EXEC;
            end
            scm_pkg::ST_EXEC:
            begin
                alu_x    = {1'b0, a_reg};
                alu_y    = {1'b0, b_reg};
                acc_next = '0;
                cnt_next = '0;
                case (cmd_reg)
                    scm_pkg::CMD_ADD:
                    begin
                        word_next  = alu_sum[W-1:0];
                        state_next = scm_pkg::ST_WB;
                    end
                    scm_pkg::CMD_SUB:
                    begin
                        alu_sub    = 1'b1;
                        word_next  = alu_sum[W-1:0];
                        state_next = scm_pkg::ST_WB;
                    end
                    scm_pkg::CMD_MUL:
                    begin
                        state_next = scm_pkg::ST_MUL;
                    end
                    scm_pkg::CMD_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            res_next    = '{status: scm_pkg::STAT_DIVZERO, top_value: '0};
                            halted_next = 1'b1;
                            state_next  = scm_pkg::ST_EMIT;
                        end
                        else
                        begin
                            neg_next   = a_reg[W-1] ^ b_reg[W-1];
                            state_next = scm_pkg::ST_ABS_A;
                        end
                    end
                    default:
                    begin
                        state_next = scm_pkg::ST_IDLE;
                    end
                endcase
            end
            scm_pkg::ST_MUL:
            begin
                // shift-add: low word of the product only
                alu_x    = {1'b0, acc_reg[W-1:0]};
                alu_y    = b_reg[0] ? {1'b0, a_reg} : '0;
                acc_next = {1'b0, alu_sum[W-1:0]};
                a_next   = {a_reg[W-2:0], 1'b0};
                b_next   = {1'b0, b_reg[W-1:1]};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                begin
                    word_next  = alu_sum[W-1:0];
                    state_next = scm_pkg::ST_WB;
                end
            end
            scm_pkg::ST_ABS_A:
            begin
                alu_y   = {1'b0, a_reg};
                alu_sub = 1'b1;
                if (a_reg[W-1])
                begin
                    a_next = alu_sum[W-1:0];
                end
                state_next = scm_pkg::ST_ABS_B;
            end
            scm_pkg::ST_ABS_B:
            begin
                alu_y   = {1'b0, b_reg};
                alu_sub = 1'b1;
                if (b_reg[W-1])
                begin
                    b_next = alu_sum[W-1:0];
                end
                state_next = scm_pkg::ST_DIV;
            end
            scm_pkg::ST_DIV:
            begin
                // restoring division, quotient shifts into a_reg
                alu_x   = {acc_reg[W-1:0], a_reg[W-1]};
                alu_y   = {1'b0, b_reg};
                alu_sub = 1'b1;
                acc_next = alu_sum[W] ? alu_x : alu_sum;
                a_next   = {a_reg[W-2:0], ~alu_sum[W]};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                begin
                    state_next = scm_pkg::ST_DIV_FIX;
                end
            end
            scm_pkg::ST_DIV_FIX:
            begin
                alu_y      = {1'b0, a_reg};
                alu_sub    = 1'b1;
                word_next  = neg_reg ? alu_sum[W-1:0] : a_reg;
                state_next = scm_pkg::ST_WB;
            end
            scm_pkg::ST_WB:
            begin
                wr_en      = 1'b1;
                wr_addr    = sp_m2[AW-1:0];
                wr_data    = word_reg;
                sp_next    = sp_m1;
                state_next = scm_pkg::ST_IDLE;
            end
            scm_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = scm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = scm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/scm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module scm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AddrWidth-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic [AddrWidth-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the stack calculator machine.
module tb;

    localparam int DEPTH       = 1024;
    localparam int QUIET_LIMIT = 1000;
    localparam int RAND_ITEMS  = 300;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    scm_pkg::req_t  req_data;
    logic           rsp_valid;
    logic           rsp_stall;
    scm_pkg::rsp_t  rsp_data;

    // calculator state as seen from the outside
    logic [31:0]    calc_stack [0:DEPTH-1];
    int             calc_depth;
    bit             calc_halted;
    scm_pkg::rsp_t  results_due[$];

    int fail_count;
    int hold_left;
    bit steady;

    stack_calculator_machine_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int pace();
        return steady ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(0, 20);
            5: return -$urandom_range(1, 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic void halt_with(input scm_pkg::status_t s);
        scm_pkg::rsp_t o;
        o.status    = s;
        o.top_value = '0;
        results_due.push_back(o);
        calc_halted = 1'b1;
    endfunction

    // expected effect of one accepted instruction
    function automatic void execute_instr(input scm_pkg::cmd_t c, input logic [31:0] v);
        scm_pkg::rsp_t o;
        logic [31:0]   a;
        logic [31:0]   b;
        logic [31:0]   r;
        if (c == scm_pkg::CMD_FINISH)
        begin
            if (!calc_halted)
            begin
                o.status    = (calc_depth == 0) ? scm_pkg::STAT_NOVALUE : scm_pkg::STAT_OK;
                o.top_value = (calc_depth == 0) ? '0 : calc_stack[calc_depth-1];
                results_due.push_back(o);
            end
            calc_depth  = 0;
            calc_halted = 1'b0;
            return;
        end
        if (calc_halted)
            return;
        case (c)
            scm_pkg::CMD_PUSH:
                if (calc_depth >= DEPTH)
                    halt_with(scm_pkg::STAT_OVER);
                else
                begin
                    calc_stack[calc_depth] = v;
                    calc_depth++;
                end
            scm_pkg::CMD_POP:
                if (calc_depth == 0)
                    halt_with(scm_pkg::STAT_UNDER);
                else
                    calc_depth--;
            scm_pkg::CMD_DUP:
                if (calc_depth == 0)
                    halt_with(scm_pkg::STAT_UNDER);
                else if (calc_depth >= DEPTH)
                    halt_with(scm_pkg::STAT_OVER);
                else
                begin
                    calc_stack[calc_depth] = calc_stack[calc_depth-1];
                    calc_depth++;
                end
            default:
                if (calc_depth < 2)
                    halt_with(scm_pkg::STAT_UNDER);
                else
                begin
                    a = calc_stack[calc_depth-2];
                    b = calc_stack[calc_depth-1];
                    if (c == scm_pkg::CMD_DIV && b == 32'h0)
                        halt_with(scm_pkg::STAT_DIVZERO);
                    else
                    begin
                        case (c)
                            scm_pkg::CMD_ADD: r = a + b;
                            scm_pkg::CMD_SUB: r = a - b;
                            scm_pkg::CMD_MUL: r = a * b;
                            default:
                                // most negative / -1 wraps back to itself
                                if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                                    r = a;
                                else
                                    r = $signed(a) / $signed(b);
                        endcase
                        calc_stack[calc_depth-2] = r;
                        calc_depth--;
                    end
                end
        endcase
    endfunction

    // valid stays high across back-to-back beats; it is only lowered for a gap
    task automatic send_beat(input scm_pkg::cmd_t c, input logic [31:0] v);
        int            gap;
        scm_pkg::req_t beat;
        gap = pace();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat.cmd     = c;
        beat.operand = v;
        req_valid <= 1'b1;
        req_data  <= beat;
        do @(posedge clk); while (req_stall);
        execute_instr(c, v);
    endtask

    task automatic pause_sender();
        req_valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0) @(posedge clk);
    endtask

    task automatic fill_stack();
        while (calc_depth < DEPTH)
        begin
            if (calc_depth > 0 && $urandom_range(0, 3) == 0)
                send_beat(scm_pkg::CMD_DUP, rand_word());
            else
                send_beat(scm_pkg::CMD_PUSH, rand_word());
        end
    endtask

    function automatic scm_pkg::cmd_t pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (calc_depth < 2 && roll < 80)
            return scm_pkg::CMD_PUSH;
        if (roll < 30)
            return scm_pkg::CMD_PUSH;
        if (roll < 38)
            return scm_pkg::CMD_POP;
        if (roll < 48)
            return scm_pkg::CMD_DUP;
        return scm_pkg::cmd_t'($urandom_range(scm_pkg::CMD_ADD, scm_pkg::CMD_DIV));
    endfunction

    task automatic t_directed();
        send_beat(scm_pkg::CMD_FINISH, 32'h0);        // empty stack: no value
        send_beat(scm_pkg::CMD_PUSH, 32'h7FFF_FFFF);
        send_beat(scm_pkg::CMD_PUSH, 32'h1);
        send_beat(scm_pkg::CMD_ADD, 32'hFFFF_FFFF);   // wraps to most negative
        send_beat(scm_pkg::CMD_DUP, 32'h0);
        send_beat(scm_pkg::CMD_MUL, 32'h0);
        send_beat(scm_pkg::CMD_FINISH, 32'h0);
        send_beat(scm_pkg::CMD_PUSH, 32'h8000_0000);
        send_beat(scm_pkg::CMD_PUSH, 32'h1);
        send_beat(scm_pkg::CMD_SUB, 32'h0);
        send_beat(scm_pkg::CMD_PUSH, 32'h8000_0000);
        send_beat(scm_pkg::CMD_PUSH, 32'hFFFF_FFFF);
        send_beat(scm_pkg::CMD_DIV, 32'h0);
        send_beat(scm_pkg::CMD_POP, 32'h0);
        send_beat(scm_pkg::CMD_FINISH, 32'h0);
        send_beat(scm_pkg::CMD_PUSH, -32'sd7);
        send_beat(scm_pkg::CMD_PUSH, 32'd2);
        send_beat(scm_pkg::CMD_DIV, 32'h0);           // truncates toward zero
        send_beat(scm_pkg::CMD_FINISH, 32'h0);
        send_beat(scm_pkg::CMD_POP, 32'h0);           // underflow, then ignored
        send_beat(scm_pkg::CMD_PUSH, 32'd5);
        send_beat(scm_pkg::CMD_FINISH, 32'h0);
        send_beat(scm_pkg::CMD_PUSH, 32'd3);
        send_beat(scm_pkg::CMD_PUSH, 32'd0);
        send_beat(scm_pkg::CMD_DIV, 32'h0);           // divide by zero
        send_beat(scm_pkg::CMD_FINISH, 32'h0);
        send_beat(scm_pkg::CMD_DUP, 32'h0);
        send_beat(scm_pkg::CMD_FINISH, 32'h0);
        send_beat(scm_pkg::CMD_PUSH, 32'd1);
        send_beat(scm_pkg::CMD_ADD, 32'h0);
        send_beat(scm_pkg::CMD_FINISH, 32'h0);
    endtask

    // one fill; the overflowing instruction is a dup or a push at random
    task automatic t_overflow();
        fill_stack();
        send_beat(scm_pkg::CMD_POP, 32'h0);
        send_beat(scm_pkg::CMD_DUP, 32'h0);           // takes the last free slot
        if ($urandom_range(0, 1) == 0)
            send_beat(scm_pkg::CMD_DUP, 32'h0);
        else
            send_beat(scm_pkg::CMD_PUSH, rand_word());
        send_beat(scm_pkg::CMD_SUB, 32'h0);           // ignored while halted
        send_beat(scm_pkg::CMD_PUSH, rand_word());
        send_beat(scm_pkg::CMD_FINISH, 32'h0);
    endtask

    // receiver holds off long enough for the block to back up to its input
    task automatic t_backpressure();
        steady    = 1'b1;
        hold_left = 300;
        repeat (6)
        begin
            send_beat(scm_pkg::CMD_PUSH, rand_word());
            send_beat(scm_pkg::CMD_FINISH, 32'h0);
        end
        steady = 1'b0;
    endtask

    task automatic t_drain_pause();
        send_beat(scm_pkg::CMD_PUSH, rand_word());
        send_beat(scm_pkg::CMD_PUSH, rand_word());
        send_beat(scm_pkg::CMD_MUL, 32'h0);
        send_beat(scm_pkg::CMD_FINISH, 32'h0);
        pause_sender();
        send_beat(scm_pkg::CMD_PUSH, rand_word());
        send_beat(scm_pkg::CMD_FINISH, 32'h0);
    endtask

    // mostly well-formed programs; some noise and some left without a finish
    task automatic t_random();
        int            counted;
        int            len;
        int            kind;
        scm_pkg::cmd_t c;
        counted = 0;
        while (counted < RAND_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
                steady = !steady;
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 14);
            repeat (len)
            begin
                if (kind == 0)
                    c = scm_pkg::cmd_t'($urandom_range(scm_pkg::CMD_PUSH, scm_pkg::CMD_DIV));
                else
                    c = pick_op();
                counted++;
                send_beat(c, rand_word());
            end
            if (kind != 1)
            begin
                send_beat(scm_pkg::CMD_FINISH, rand_word());
                counted++;
            end
            if ($urandom_range(0, 24) == 0)
                pause_sender();
        end
        steady = 1'b0;
    endtask

    // result side stall pattern
    initial
    begin
        int wait_left;
        wait_left = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
                wait_left = pace();
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (wait_left > 0)
            begin
                wait_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // result checker
    initial
    begin
        scm_pkg::rsp_t exp_rsp;
        scm_pkg::rsp_t got;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                got = rsp_data;
                if (results_due.size() == 0)
                begin
                    $error("unexpected result beat: status %0d top_value %0d",
                           got.status, got.top_value);
                    fail_count++;
                end
                else
                begin
                    exp_rsp = results_due.pop_front();
                    if (got.status !== exp_rsp.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_rsp.status, got.status);
                        fail_count++;
                    end
                    if (got.top_value !== exp_rsp.top_value)
                    begin
                        $error("top_value: expected %0d, got %0d",
                               exp_rsp.top_value, got.top_value);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog: cycles with no beat on either side
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("stack_calculator_machine_top test failed");
        $finish;
    end

    initial
    begin
        fail_count  = 0;
        hold_left   = 0;
        steady      = 1'b0;
        calc_depth  = 0;
        calc_halted = 1'b0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        t_directed();
        t_overflow();
        t_backpressure();
        t_drain_pause();
        t_random();
        req_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("stack_calculator_machine_top test passed");
        else
            $display("stack_calculator_machine_top test failed");
        $finish;
    end

endmodule
